@@ rtl/mark_release_stack_allocator_top_assert.svh @@
// assertion macros for the mark release stack allocator
`ifndef MARK_RELEASE_STACK_ALLOCATOR_TOP_ASSERT_SVH
`define MARK_RELEASE_STACK_ALLOCATOR_TOP_ASSERT_SVH
`define MRSA_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define MRSA_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

@@ rtl/mrsa_pkg.sv @@
// shared types and constants for the mark release stack allocator
`timescale 1ns / 1ps
package mrsa_pkg;
	localparam int unsigned MaxHeaders = 64;
	localparam int unsigned Alignment = 32;
	localparam logic [31:0] Word = 32'd4;
	localparam logic [31:0] FlagOverlay = 32'h1;
	localparam logic [31:0] FlagPermanent = 32'h2;

	localparam logic [3:0] CmdInit = 4'd0;
	localparam logic [3:0] CmdAlloc = 4'd1;
	localparam logic [3:0] CmdAllocAll = 4'd2;
	localparam logic [3:0] CmdFree = 4'd3;
	localparam logic [3:0] CmdFreeAll = 4'd4;
	localparam logic [3:0] CmdMark = 4'd5;
	localparam logic [3:0] CmdMarkPerm = 4'd6;
	localparam logic [3:0] CmdFreeToMark = 4'd7;
	localparam logic [3:0] CmdFreePastPerm = 4'd8;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StOom = 2'd1;
	localparam logic [1:0] StZero = 2'd2;
	localparam logic [1:0] StFull = 2'd3;

	localparam logic [2:0] RegTop = 3'd0;
	localparam logic [2:0] RegFloor = 3'd1;
	localparam logic [2:0] RegOvEn = 3'd2;
	localparam logic [2:0] RegOvFloor = 3'd3;
	localparam logic [2:0] RegOvCeil = 3'd4;

	typedef struct packed {
		logic load;
		logic exec;
		logic pop;
		logic rd;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic empty;
		logic pop_stop;
		logic is_multi;
	} sts_t;
endpackage

@@ rtl/mrsa_ctrl.sv @@
// controller state machine for the mark release stack allocator
`timescale 1ns / 1ps
module mrsa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input mrsa_pkg::sts_t sts,
	output mrsa_pkg::ctl_t ctl
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RD = 5'b00100,
		S_POP = 5'b01000,
		S_OUT = 5'b10000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_multi && !sts.empty) begin
					ctl.rd = 1'b1;
					state_d = S_RD;
				end else begin
					ctl.exec = 1'b1;
					ctl.finish = 1'b1;
					state_d = S_OUT;
				end
			end
			S_RD: state_d = S_POP;
			S_POP: begin
				if (sts.pop_stop) begin
					ctl.finish = 1'b1;
					state_d = S_OUT;
				end else begin
					ctl.pop = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

@@ rtl/mrsa_dpath.sv @@
// datapath of the mark release stack allocator with header memory
`timescale 1ns / 1ps
module mrsa_dpath #(
	parameter int unsigned MAX_HEADERS = mrsa_pkg::MaxHeaders,
	parameter int unsigned ALIGNMENT = mrsa_pkg::Alignment
) (
	input logic clk,
	input logic arst_n,
	input mrsa_pkg::ctl_t ctl,
	output mrsa_pkg::sts_t sts,
	input logic [3:0] command,
	input logic [31:0] request_size,
	input logic [1:0] hints,
	input logic [31:0] region_top,
	input logic [31:0] region_floor,
	input logic overlay_enable,
	input logic [31:0] overlay_floor,
	input logic [31:0] overlay_ceiling,
	output logic [31:0] address,
	output logic [31:0] granted_size,
	output logic [1:0] status,
	output logic [31:0] stack_pointer,
	output logic [31:0] available
);
	localparam int CW = $clog2(MAX_HEADERS + 1);
	localparam int AW = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1;
	localparam int LA = $clog2(ALIGNMENT);
	localparam logic [32:0] AL33 = 33'(ALIGNMENT);
	localparam logic [31:0] AL32 = 32'(ALIGNMENT);
	localparam logic [31:0] AMASK = AL32 - 32'd1;

	logic [31:0] header_mem [MAX_HEADERS];
	logic [31:0] rd_q;
	logic [3:0] cmd_q;
	logic [31:0] req_q;
	logic [1:0] hints_q;
	logic [31:0] top_q, ovt_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] addr_q, gsz_q;
	logic [1:0] st_q;
	logic [AW-1:0] last_idx;
	logic align, use_ov;
	logic [32:0] r_wd, r_al, need;
	logic [31:0] rs, ov_free, room32, temp, sz, aa_addr, inc, sz2;
	logic fail_oom, full, room_ok, ov_fit;
	logic [33:0] room;
	logic [31:0] ph, ph_sz;
	logic pop_done_q;

	assign last_idx = AW'(cnt_q - CW'(1));
	assign align = hints_q[0];
	assign use_ov = overlay_enable && !hints_q[1];
	assign full = (cnt_q >= CW'(MAX_HEADERS));
	assign ov_free = ovt_q - overlay_floor;
	assign room = {2'b0, top_q} - {2'b0, region_floor} - 34'd4;
	assign room_ok = !room[33] && (room[32:0] >= 33'd4);
	assign room32 = room[31:0];

	always_comb begin
		r_wd = ({1'b0, req_q} + 33'd3) & ~33'd3;
		r_al = (((r_wd + AL33 - 33'd1) >> LA) << LA) + AL33 - 33'd4;
		if (align) r_wd = r_al;
		need = r_wd + 33'd4;
		rs = r_wd[31:0];
		fail_oom = ({2'b0, top_q} < ({2'b0, region_floor} + {1'b0, need}));
		ov_fit = use_ov && (ov_free >= rs);
		temp = room32;
		if (use_ov && ov_free < temp) temp = ov_free;
		sz = temp & ~32'd3;
		aa_addr = use_ov ? (ovt_q - sz) : (top_q - sz);
		inc = AL32 - (aa_addr & AMASK);
		sz2 = sz;
		if (align && (aa_addr & AMASK) != 32'd0) sz2 = (sz >= inc) ? sz - inc : 32'd0;
		if (align) sz2 = sz2 & ~AMASK;
		ph = rd_q & ~mrsa_pkg::FlagPermanent;
		ph_sz = ph & ~mrsa_pkg::FlagOverlay;
	end

	function automatic logic [31:0] aup(input logic [31:0] a);
		logic [31:0] o;
		o = a & AMASK;
		return (o != 32'd0) ? (a + (AL32 - o)) : a;
	endfunction

	assign sts.empty = (cnt_q == '0) || pop_done_q;
	assign sts.is_multi = (cmd_q == mrsa_pkg::CmdFreeAll) ||
		(cmd_q == mrsa_pkg::CmdFreeToMark) || (cmd_q == mrsa_pkg::CmdFreePastPerm) ||
		(cmd_q == mrsa_pkg::CmdFree) || (cmd_q == mrsa_pkg::CmdMarkPerm);
	assign sts.pop_stop = ((cmd_q == mrsa_pkg::CmdFreeToMark) &&
		((rd_q & mrsa_pkg::FlagPermanent) != 0)) || (cmd_q == mrsa_pkg::CmdMarkPerm);

	logic pop_mark;
	assign pop_mark = (cmd_q != mrsa_pkg::CmdFreeAll) && (ph_sz == mrsa_pkg::Word);

	always_ff @(posedge clk) begin
		if (ctl.rd) rd_q <= header_mem[last_idx];
		if (ctl.exec) begin
			priority if (cmd_q == mrsa_pkg::CmdAlloc && req_q != '0 && !fail_oom && !full)
				header_mem[cnt_q[AW-1:0]] <= (rs + 32'd4) | (ov_fit ? mrsa_pkg::FlagOverlay : '0);
			else if (cmd_q == mrsa_pkg::CmdAllocAll && room_ok && !full)
				header_mem[cnt_q[AW-1:0]] <= (sz + 32'd4) |
					(use_ov ? mrsa_pkg::FlagOverlay : '0);
			else if (cmd_q == mrsa_pkg::CmdMark && top_q >= region_floor + 32'd4 &&
				{1'b0, region_floor} + 33'd4 <= {1'b0, top_q} && !full)
				header_mem[cnt_q[AW-1:0]] <= mrsa_pkg::Word;
		end
		if (ctl.finish && cmd_q == mrsa_pkg::CmdMarkPerm && cnt_q != '0)
			header_mem[last_idx] <= rd_q | mrsa_pkg::FlagPermanent;
	end

	logic mark_oom;
	assign mark_oom = {1'b0, top_q} < {1'b0, region_floor} + 33'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0; ovt_q <= '0; cnt_q <= '0; pop_done_q <= 1'b0;
		end else begin
			if (ctl.load) pop_done_q <= 1'b0;
			if (ctl.pop) begin
				cnt_q <= cnt_q - CW'(1);
				top_q <= top_q + ph_sz;
				if (ph[0]) ovt_q <= ovt_q + ph_sz - 32'd4;
				if (pop_mark || cmd_q == mrsa_pkg::CmdFree) pop_done_q <= 1'b1;
			end
			if (ctl.exec) begin
				unique case (cmd_q)
					mrsa_pkg::CmdInit: begin
						top_q <= region_top; ovt_q <= overlay_ceiling; cnt_q <= '0;
					end
					mrsa_pkg::CmdAlloc: if (req_q != '0 && !fail_oom && !full) begin
						top_q <= top_q - rs - 32'd4;
						if (ov_fit) ovt_q <= ovt_q - rs;
						cnt_q <= cnt_q + CW'(1);
					end
					mrsa_pkg::CmdAllocAll: if (room_ok && !full) begin
						top_q <= top_q - sz - 32'd4;
						if (use_ov) ovt_q <= ovt_q - sz;
						cnt_q <= cnt_q + CW'(1);
					end
					mrsa_pkg::CmdMark: if (!mark_oom && !full) begin
						top_q <= top_q - 32'd4;
						cnt_q <= cnt_q + CW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command; req_q <= request_size; hints_q <= hints;
		end
		if (ctl.finish) begin
			addr_q <= '0; gsz_q <= '0; st_q <= mrsa_pkg::StOk;
			if (ctl.exec) begin
				unique case (cmd_q)
					mrsa_pkg::CmdAlloc: begin
						priority if (req_q == '0) st_q <= mrsa_pkg::StZero;
						else if (fail_oom) st_q <= mrsa_pkg::StOom;
						else if (full) st_q <= mrsa_pkg::StFull;
						else begin
							addr_q <= align ? aup(ov_fit ? ovt_q - rs : top_q - rs)
								: (ov_fit ? ovt_q - rs : top_q - rs);
							gsz_q <= rs;
						end
					end
					mrsa_pkg::CmdAllocAll: begin
						priority if (!room_ok) st_q <= mrsa_pkg::StOom;
						else if (full) st_q <= mrsa_pkg::StFull;
						else begin
							addr_q <= align ? aup(aa_addr) : aa_addr;
							gsz_q <= sz2;
						end
					end
					mrsa_pkg::CmdMark: begin
						priority if (mark_oom) st_q <= mrsa_pkg::StOom;
						else if (full) st_q <= mrsa_pkg::StFull;
					end
					default: ;
				endcase
			end
		end
	end

	// free-one pops through the same popping path
	logic [31:0] sp_free;
	assign sp_free = top_q;
	assign address = addr_q;
	assign granted_size = gsz_q;
	assign status = st_q;
	assign stack_pointer = sp_free;
	assign available = room_ok ? room32 : 32'd0;
endmodule

@@ rtl/mark_release_stack_allocator_top.sv @@
// mark release stack allocator: one transaction at a time; a non-popping command is loaded,
// executed and its result held until taken, and mark_permanent reads the top header first
// free, free_all and the free-to-mark commands pop headers one by one until they stop, and
// free-to-mark stops at a permanent header; next input is accepted after the result is taken
// each pop is one header memory read, a wait and an update, set by the single read port
// reset clears config registers, stack and header count; header memory and result registers are not cleared
`timescale 1ns / 1ps
`include "mark_release_stack_allocator_top_assert.svh"
module mark_release_stack_allocator_top #(
	parameter int unsigned MAX_HEADERS = mrsa_pkg::MaxHeaders,
	parameter int unsigned ALIGNMENT = mrsa_pkg::Alignment
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [3:0] command,
	input logic [31:0] request_size,
	input logic [1:0] hints,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] address,
	output logic [31:0] granted_size,
	output logic [1:0] status,
	output logic [31:0] stack_pointer,
	output logic [31:0] available,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	logic [31:0] region_top_q, region_floor_q, overlay_floor_q, overlay_ceiling_q;
	logic overlay_enable_q;
	mrsa_pkg::ctl_t ctl;
	mrsa_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_top_q <= '0; region_floor_q <= '0; overlay_enable_q <= 1'b0;
			overlay_floor_q <= '0; overlay_ceiling_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrsa_pkg::RegTop: region_top_q <= cfg_data;
				mrsa_pkg::RegFloor: region_floor_q <= cfg_data;
				mrsa_pkg::RegOvEn: overlay_enable_q <= cfg_data[0];
				mrsa_pkg::RegOvFloor: overlay_floor_q <= cfg_data;
				mrsa_pkg::RegOvCeil: overlay_ceiling_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
	);

	mrsa_dpath #(.MAX_HEADERS(MAX_HEADERS), .ALIGNMENT(ALIGNMENT)) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(command), .request_size(request_size), .hints(hints),
		.region_top(region_top_q), .region_floor(region_floor_q),
		.overlay_enable(overlay_enable_q), .overlay_floor(overlay_floor_q),
		.overlay_ceiling(overlay_ceiling_q),
		.address(address), .granted_size(granted_size), .status(status),
		.stack_pointer(stack_pointer), .available(available)
	);

	`MRSA_ASSERT_IMPL(a_no_overlap, out_valid, in_stall)
	`MRSA_ASSERT_NEXT(a_load_busy, in_valid && !in_stall, in_stall)
	`MRSA_ASSERT_IMPL(a_status_range, out_valid && (address != 32'd0), status == mrsa_pkg::StOk)
endmodule

@@ bench/mark_release_stack_allocator_top_tb.sv @@
// testbench for the mark release stack allocator: directed and random commands
`timescale 1ns / 1ps
module mark_release_stack_allocator_top_tb;
	localparam logic [3:0] CmdQuery = 4'd9;
	localparam int unsigned WatchLimit = 40000;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] granted_size;
		logic [1:0] status;
		logic [31:0] stack_pointer;
		logic [31:0] available;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] command = '0;
	logic [31:0] request_size = '0;
	logic [1:0] hints = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] address, granted_size, stack_pointer, available;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	mark_release_stack_allocator_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] p_top, p_floor, p_ovfloor, p_ovceil;
	logic p_oven;
	logic [31:0] p_sp, p_ovtop;
	logic [31:0] p_hdr [mrsa_pkg::MaxHeaders];
	int unsigned p_cnt;

	alloc_result_t expected_q[$];
	int unsigned mismatches = 0;
	int unsigned send_idle = 0, recv_idle = 0;
	int unsigned quiet = 0;

	function automatic logic [31:0] pop_header();
		logic [31:0] h;
		h = p_hdr[p_cnt - 1] & ~mrsa_pkg::FlagPermanent;
		p_cnt--;
		if (h & mrsa_pkg::FlagOverlay) begin
			h &= ~mrsa_pkg::FlagOverlay;
			p_ovtop = p_ovtop + h - mrsa_pkg::Word;
		end
		p_sp = p_sp + h;
		return h;
	endfunction

	function automatic logic [1:0] push_check(logic [32:0] need);
		if ({1'b0, p_sp} < {1'b0, p_floor} + {1'b0, need}) return mrsa_pkg::StOom;
		if (p_cnt >= mrsa_pkg::MaxHeaders) return mrsa_pkg::StFull;
		return mrsa_pkg::StOk;
	endfunction

	function automatic logic [31:0] free_room();
		longint room;
		room = longint'(p_sp) - longint'(p_floor) - 4;
		return (room < 4) ? 32'd0 : room[31:0];
	endfunction

	function automatic alloc_result_t predict_alloc(logic [3:0] cmd, logic [31:0] req,
			logic [1:0] hn);
		alloc_result_t r;
		logic al, use_ov;
		logic [32:0] rs33;
		logic [31:0] rs, hdr, ovf, tmp, off, inc;
		longint room;
		r = '0;
		al = hn[0];
		use_ov = p_oven && !hn[1];
		case (cmd)
			mrsa_pkg::CmdInit: begin
				p_sp = p_top;
				p_ovtop = p_ovceil;
				p_cnt = 0;
			end
			mrsa_pkg::CmdAlloc: begin
				if (req == 0) begin
					r.status = mrsa_pkg::StZero;
				end else begin
					rs33 = ({1'b0, req} + 33'd3) & ~33'd3;
					if (al) begin
						rs33 = ((rs33 + mrsa_pkg::Alignment - 1) / mrsa_pkg::Alignment) *
							mrsa_pkg::Alignment;
						rs33 = rs33 + mrsa_pkg::Alignment - 4;
					end
					r.status = push_check(rs33 + 33'd4);
					if (r.status == mrsa_pkg::StOk) begin
						rs = rs33[31:0];
						hdr = rs + mrsa_pkg::Word;
						r.address = p_sp - rs;
						p_sp = r.address - mrsa_pkg::Word;
						ovf = p_ovtop - p_ovfloor;
						if (use_ov && ovf >= rs) begin
							p_ovtop = p_ovtop - rs;
							r.address = p_ovtop;
							hdr |= mrsa_pkg::FlagOverlay;
						end
						p_hdr[p_cnt] = hdr;
						p_cnt++;
						if (al && (r.address % mrsa_pkg::Alignment) != 0)
							r.address = r.address + (mrsa_pkg::Alignment -
								r.address % mrsa_pkg::Alignment);
						r.granted_size = rs;
					end
				end
			end
			mrsa_pkg::CmdAllocAll: begin
				room = longint'(p_sp) - longint'(p_floor) - 4;
				if (room < 4) begin
					r.status = mrsa_pkg::StOom;
				end else if (p_cnt >= mrsa_pkg::MaxHeaders) begin
					r.status = mrsa_pkg::StFull;
				end else begin
					tmp = room[31:0];
					if (use_ov) begin
						ovf = p_ovtop - p_ovfloor;
						if (ovf < tmp) tmp = ovf;
					end
					rs = tmp & ~32'd3;
					r.address = p_sp - rs;
					p_sp = r.address - mrsa_pkg::Word;
					hdr = rs + mrsa_pkg::Word;
					if (use_ov) begin
						p_ovtop = p_ovtop - rs;
						r.address = p_ovtop;
						hdr |= mrsa_pkg::FlagOverlay;
					end
					p_hdr[p_cnt] = hdr;
					p_cnt++;
					if (al) begin
						off = r.address % mrsa_pkg::Alignment;
						if (off != 0) begin
							inc = mrsa_pkg::Alignment - off;
							r.address = r.address + inc;
							rs = (rs >= inc) ? rs - inc : 32'd0;
						end
						rs = (rs / mrsa_pkg::Alignment) * mrsa_pkg::Alignment;
					end
					r.granted_size = rs;
				end
			end
			mrsa_pkg::CmdFree: if (p_cnt > 0) void'(pop_header());
			mrsa_pkg::CmdFreeAll: while (p_cnt > 0) void'(pop_header());
			mrsa_pkg::CmdMark: begin
				r.status = push_check(33'd4);
				if (r.status == mrsa_pkg::StOk) begin
					p_sp = p_sp - mrsa_pkg::Word;
					p_hdr[p_cnt] = mrsa_pkg::Word;
					p_cnt++;
				end
			end
			mrsa_pkg::CmdMarkPerm: if (p_cnt > 0) p_hdr[p_cnt - 1] |= mrsa_pkg::FlagPermanent;
			mrsa_pkg::CmdFreeToMark, mrsa_pkg::CmdFreePastPerm: begin
				while (p_cnt > 0) begin
					if (cmd == mrsa_pkg::CmdFreeToMark &&
						(p_hdr[p_cnt - 1] & mrsa_pkg::FlagPermanent)) break;
					if (pop_header() == mrsa_pkg::Word) break;
				end
			end
			default: ;
		endcase
		r.stack_pointer = p_sp;
		r.available = free_room();
		return r;
	endfunction

	task automatic send_command(logic [3:0] cmd, logic [31:0] req, logic [1:0] hn);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		request_size <= req;
		hints <= hn;
		expected_q.push_back(predict_alloc(cmd, req, hn));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			mrsa_pkg::RegTop: p_top = val;
			mrsa_pkg::RegFloor: p_floor = val;
			mrsa_pkg::RegOvEn: p_oven = val[0];
			mrsa_pkg::RegOvFloor: p_ovfloor = val;
			mrsa_pkg::RegOvCeil: p_ovceil = val;
			default: ;
		endcase
	endtask

	task automatic set_regions(logic [31:0] top, logic [31:0] flr, logic oven,
			logic [31:0] ovf, logic [31:0] ovc);
		drain();
		write_reg(mrsa_pkg::RegTop, top);
		write_reg(mrsa_pkg::RegFloor, flr);
		write_reg(mrsa_pkg::RegOvEn, {31'd0, oven});
		write_reg(mrsa_pkg::RegOvFloor, ovf);
		write_reg(mrsa_pkg::RegOvCeil, ovc);
		send_command(mrsa_pkg::CmdInit, $urandom, 2'($urandom));
	endtask

	always @(posedge clk) begin
		alloc_result_t got, exp;
		out_stall <= ($urandom_range(99) < recv_idle);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {address, granted_size, status, stack_pointer, available};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %h", got);
			end else begin
				exp = expected_q.pop_front();
				if (got !== exp) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp adr %h sz %h st %0d sp %h av %h",
							" got adr %h sz %h st %0d sp %h av %h"},
							exp.address, exp.granted_size, exp.status, exp.stack_pointer,
							exp.available, got.address, got.granted_size, got.status,
							got.stack_pointer, got.available);
				end
			end
		end
	end

	task automatic test_directed();
		send_command(CmdQuery, 32'hffff_ffff, 2'd3);
		send_command(mrsa_pkg::CmdAlloc, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdAlloc, 32'd4, 2'd0);
		send_command(mrsa_pkg::CmdFree, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdFreeAll, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdFreeToMark, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdMarkPerm, 32'd0, 2'd0);
		set_regions(32'h0001_0000, 32'h0000_8000, 1'b1, 32'h2000_0000, 32'h2000_0100);
		send_command(mrsa_pkg::CmdMark, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdAlloc, 32'd1, 2'd0);
		send_command(mrsa_pkg::CmdAlloc, 32'd77, 2'd1);
		send_command(mrsa_pkg::CmdAlloc, 32'd200, 2'd2);
		send_command(mrsa_pkg::CmdAlloc, 32'd300, 2'd0);
		send_command(mrsa_pkg::CmdMarkPerm, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdMark, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdAlloc, 32'd16, 2'd3);
		send_command(mrsa_pkg::CmdFreeToMark, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdFreeToMark, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdFreePastPerm, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdAllocAll, 32'd0, 2'd1);
		send_command(mrsa_pkg::CmdAllocAll, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdAlloc, 32'hffff_ffff, 2'd1);
		send_command(4'd15, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdFreeAll, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdAllocAll, 32'd0, 2'd2);
	endtask

	task automatic test_header_full();
		set_regions(32'hffff_fffc, 32'd0, 1'b0, 32'd0, 32'd0);
		repeat (mrsa_pkg::MaxHeaders + 2)
			send_command(mrsa_pkg::CmdMark, 32'd0, 2'($urandom));
		send_command(mrsa_pkg::CmdAlloc, 32'd8, 2'd0);
		send_command(mrsa_pkg::CmdAllocAll, 32'd0, 2'd0);
		send_command(mrsa_pkg::CmdFreeAll, 32'd0, 2'd0);
	endtask

	task automatic test_random(int unsigned n);
		int unsigned k;
		logic [3:0] cmd;
		logic [31:0] req;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 200 == 0) begin
				k = $urandom_range(3);
				case (k)
					0: set_regions(32'h0000_4000, 32'h0000_1000, 1'b1,
						32'h8000_0000, 32'h8000_0400);
					1: set_regions($urandom & ~32'd3, $urandom, 1'b1, $urandom, $urandom);
					2: set_regions(32'h0000_0800, 32'h0000_0000, 1'b0,
						32'hffff_fff0, 32'h0000_0010);
					default: set_regions(32'hffff_fffc, 32'hffff_f000, 1'($urandom),
						32'd0, 32'd64);
				endcase
			end
			k = $urandom_range(99);
			if (k < 40) cmd = mrsa_pkg::CmdAlloc;
			else if (k < 50) cmd = mrsa_pkg::CmdMark;
			else if (k < 56) cmd = mrsa_pkg::CmdMarkPerm;
			else if (k < 66) cmd = mrsa_pkg::CmdFree;
			else if (k < 76) cmd = mrsa_pkg::CmdFreeToMark;
			else if (k < 82) cmd = mrsa_pkg::CmdFreePastPerm;
			else if (k < 87) cmd = mrsa_pkg::CmdAllocAll;
			else if (k < 90) cmd = mrsa_pkg::CmdFreeAll;
			else if (k < 92) cmd = mrsa_pkg::CmdInit;
			else cmd = 4'($urandom_range(9, 15));
			k = $urandom_range(9);
			if (k < 7) req = $urandom_range(0, 300);
			else if (k < 9) req = $urandom;
			else req = 32'hffff_ffff - $urandom_range(7);
			send_command(cmd, req, 2'($urandom));
		end
	endtask

	initial begin
		p_top = 0; p_floor = 0; p_oven = 0; p_ovfloor = 0; p_ovceil = 0;
		p_sp = 0; p_ovtop = 0; p_cnt = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 30; recv_idle = 78;
		test_directed();
		test_header_full();
		test_random(500);
		send_idle = 78; recv_idle = 30;
		test_random(500);
		send_idle = 0; recv_idle = 0;
		test_random(500);
		drain();
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
